/* hw/rtl/rmt_pkg.sv */
// ----------------------------------------------------------------------------
// rmt_pkg
// shared types and constants for the range maximum point update tree
// ----------------------------------------------------------------------------
package rmt_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W = 11;
   localparam int unsigned LEAF_COUNT_DEF = 1024;
   localparam logic [POS_W-1:0] ELEMENT_COUNT_RST = 11'd1024;

   // request tdata layout, lowest bit first
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned POS_LSB = 0;
   localparam int unsigned VAL_LSB = POS_LSB + POS_W;
   localparam int unsigned LB_LSB = VAL_LSB + DATA_W;
   localparam int unsigned RB_LSB = LB_LSB + POS_W;
   localparam int unsigned RSP_TDATA_W = 32;

   // command codes carried in req_tuser
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY,
      ST_DRAIN,
      ST_RESULT
   } rmt_state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic upd_step;
      logic qry_step;
      logic drain;
      logic resp_load;
   } rmt_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_query;
      logic in_ok;
      logic upd_last;
      logic qry_last;
      logic rsp_free;
   } rmt_status_type;

endpackage

/* hw/rtl/rmt_ctrl.sv */
// ----------------------------------------------------------------------------
// rmt_ctrl
// sequencer for clearing, updates, queries and result hand-off
// ----------------------------------------------------------------------------
module rmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rmt_pkg::rmt_status_type sts,
   output rmt_pkg::rmt_cmd_type    cmd
);

   rmt_pkg::rmt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         rmt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = rmt_pkg::ST_IDLE;
            end
         end
         rmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (sts.in_query) begin
                  state_in = sts.in_ok ? rmt_pkg::ST_QUERY : rmt_pkg::ST_RESULT;
               end else if (sts.in_ok) begin
                  state_in = rmt_pkg::ST_UPDATE;
               end
            end
         end
         rmt_pkg::ST_UPDATE: begin
            cmd.upd_step = 1'b1;
            if (sts.upd_last) begin
               state_in = rmt_pkg::ST_IDLE;
            end
         end
         rmt_pkg::ST_QUERY: begin
            cmd.qry_step = 1'b1;
            if (sts.qry_last) begin
               state_in = rmt_pkg::ST_DRAIN;
            end
         end
         rmt_pkg::ST_DRAIN: begin
            cmd.drain = 1'b1;
            state_in = rmt_pkg::ST_RESULT;
         end
         rmt_pkg::ST_RESULT: begin
            if (sts.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in = rmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/rmt_datapath.sv */
// ----------------------------------------------------------------------------
// rmt_datapath
// node memory, path walk for updates, range walk for queries, result register
// ----------------------------------------------------------------------------
module rmt_datapath #(
   parameter int unsigned LEAF_COUNT = rmt_pkg::LEAF_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tuser,
   input  logic [rmt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [rmt_pkg::POS_W-1:0]          element_count,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [rmt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   input  rmt_pkg::rmt_cmd_type               cmd,
   output rmt_pkg::rmt_status_type            sts
);

   localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT;
   localparam int unsigned NODE_W = $clog2(NODE_COUNT);
   localparam int unsigned IDX_W = NODE_W + 1;
   localparam int unsigned CW = (rmt_pkg::POS_W > IDX_W) ? rmt_pkg::POS_W : IDX_W;
   localparam int unsigned DW = rmt_pkg::DATA_W;
   localparam int unsigned PW = rmt_pkg::POS_W;

   logic [DW-1:0] node_mem [NODE_COUNT];

   // request fields
   logic [PW-1:0] pos, lb, rb;
   logic [DW-1:0] new_val;
   logic [CW-1:0] pos_x, lb_x, rb_x, cnt_x, leaf_x;

   // memory ports
   logic          wr_en;
   logic [NODE_W-1:0] wr_addr, rd0_addr, rd1_addr;
   logic [DW-1:0] wr_data, rd0_data_ff, rd1_data_ff;

   // walk state
   logic [NODE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NODE_W-1:0] node_ff, node_in, parent;
   logic signed [DW-1:0] cur_ff, cur_in, sib, up_max;
   logic first_ff, first_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, lo_a, hi_a, hi_dec, lo_n, hi_n;
   logic take0_ff, take0_in, take1_ff, take1_in;
   logic signed [DW-1:0] best_ff, best_in, m1, m2, cand0, cand1;
   logic have_ff, have_in, h1;
   logic err_ff, err_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_max_ff, rsp_max_in;
   logic rsp_err_ff, rsp_err_in;

   assign pos = req_tdata[rmt_pkg::POS_LSB +: PW];
   assign new_val = req_tdata[rmt_pkg::VAL_LSB +: DW];
   assign lb = req_tdata[rmt_pkg::LB_LSB +: PW];
   assign rb = req_tdata[rmt_pkg::RB_LSB +: PW];
   assign pos_x = CW'(pos);
   assign lb_x = CW'(lb);
   assign rb_x = CW'(rb);
   assign cnt_x = CW'(element_count);
   assign leaf_x = CW'(LEAF_COUNT);

   // bound checks on the incoming item
   assign sts.in_ok = (req_tuser == rmt_pkg::CMD_QUERY) ?
      ((lb_x != '0) && (lb_x <= rb_x) && (rb_x <= cnt_x) && (rb_x <= leaf_x)) :
      ((pos_x != '0) && (pos_x <= cnt_x) && (pos_x <= leaf_x));
   assign sts.in_query = (req_tuser == rmt_pkg::CMD_QUERY);

   // update path: parent of the current node and its refreshed maximum
   assign parent = node_ff >> 1;
   assign sib = rd0_data_ff;
   assign up_max = (cur_ff > sib) ? cur_ff : sib;
   assign sts.upd_last = !first_ff && (parent == NODE_W'(1));

   // query walk: nodes taken at this level and the bounds one level up
   assign lo_a = lo_ff + IDX_W'(lo_ff[0]);
   assign hi_a = hi_ff - IDX_W'(hi_ff[0]);
   assign hi_dec = hi_ff - IDX_W'(1);
   assign lo_n = lo_a >> 1;
   assign hi_n = hi_a >> 1;
   assign sts.qry_last = !(lo_n < hi_n);

   // fold in the nodes read last cycle, left one first
   always_comb begin
      cand0 = rd0_data_ff;
      cand1 = rd1_data_ff;
      m1 = best_ff;
      if (take0_ff) begin
         m1 = (have_ff && (best_ff > cand0)) ? best_ff : cand0;
      end
      h1 = have_ff | take0_ff;
      m2 = m1;
      if (take1_ff) begin
         m2 = (h1 && (m1 > cand1)) ? m1 : cand1;
      end
   end

   assign sts.clear_last = (clr_cnt_ff == NODE_W'(NODE_COUNT - 1));
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   // memory port selection
   always_comb begin
      wr_en = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.upd_step) begin
         wr_en = 1'b1;
         wr_addr = first_ff ? node_ff : parent;
         wr_data = first_ff ? cur_ff : up_max;
      end
      if (cmd.qry_step) begin
         rd0_addr = lo_ff[NODE_W-1:0];
      end else begin
         rd0_addr = first_ff ? (node_ff ^ NODE_W'(1)) : (parent ^ NODE_W'(1));
      end
      rd1_addr = hi_dec[NODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd0_data_ff <= node_mem[rd0_addr];
      rd1_data_ff <= node_mem[rd1_addr];
   end

   // next values of the walk registers
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      node_in = node_ff;
      cur_in = cur_ff;
      first_in = first_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      take0_in = take0_ff;
      take1_in = take1_ff;
      best_in = best_ff;
      have_in = have_ff;
      err_in = err_ff;
      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + NODE_W'(1);
      end
      if (cmd.load) begin
         node_in = NODE_W'(LEAF_COUNT) + NODE_W'(pos) - NODE_W'(1);
         cur_in = new_val;
         first_in = 1'b1;
         lo_in = IDX_W'(LEAF_COUNT) + IDX_W'(lb) - IDX_W'(1);
         hi_in = IDX_W'(LEAF_COUNT) + IDX_W'(rb);
         take0_in = 1'b0;
         take1_in = 1'b0;
         have_in = 1'b0;
         err_in = (req_tuser == rmt_pkg::CMD_QUERY) && !sts.in_ok;
      end
      if (cmd.upd_step) begin
         first_in = 1'b0;
         if (!first_ff) begin
            node_in = parent;
            cur_in = up_max;
         end
      end
      if (cmd.qry_step || cmd.drain) begin
         best_in = m2;
         have_in = h1 | take1_ff;
         take0_in = cmd.qry_step & lo_ff[0];
         take1_in = cmd.qry_step & hi_ff[0];
      end
      if (cmd.qry_step) begin
         lo_in = lo_n;
         hi_in = hi_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         first_ff <= 1'b0;
         take0_ff <= 1'b0;
         take1_ff <= 1'b0;
         have_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         first_ff <= first_in;
         take0_ff <= take0_in;
         take1_ff <= take1_in;
         have_ff <= have_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff <= cur_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      best_ff <= best_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_max_in = rsp_max_ff;
      rsp_err_in = rsp_err_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
         rsp_max_in = err_ff ? '0 : best_ff;
         rsp_err_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_max_ff <= rsp_max_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_max_ff;
   assign rsp_tuser = rsp_err_ff;

endmodule

/* hw/rtl/range_max_point_update_tree_top.sv */
// ----------------------------------------------------------------------------
// range_max_point_update_tree_top
// segment tree of signed maxima with point updates and range maximum queries
// ----------------------------------------------------------------------------
//  channel  direction  handshake                ports
//  req      in         req_tvalid/req_tready    req_tdata, req_tuser
//  rsp      out        rsp_tvalid/rsp_tready    rsp_tdata, rsp_tuser
//  csr      in         csr_wr_en (no wait)      csr_wr_data
//
//  an update in range runs through the accept, the leaf write, then one parent
//    write per tree level
//  a query in range runs through the accept, one level per cycle on the two
//    memory read ports, a drain step, and the result load
//  the node memory has one write and two read ports; it sets the pace
//  after reset a clearing pass writes zero to all 2*LEAF_COUNT nodes;
//    no item is accepted during it
//  req is taken while an earlier result still waits on rsp; a new result
//    waits in the block until the output register frees up
module range_max_point_update_tree_top #(
   parameter int unsigned LEAF_COUNT = rmt_pkg::LEAF_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // position[10:0], new_value[42:11], left_bound[53:43], right_bound[64:54]
   input  logic [rmt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command: 0 update, 1 query
   input  logic                             req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // range_maximum[31:0]
   output logic [rmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // range_error
   output logic                             rsp_tuser,
   // element count register
   input  logic                             csr_wr_en,
   input  logic [rmt_pkg::POS_W-1:0]        csr_wr_data
);

   // element count, positions 1 up to this value are in use
   logic [rmt_pkg::POS_W-1:0] element_count_ff, element_count_in;

   rmt_pkg::rmt_cmd_type    ctrl_cmd;
   rmt_pkg::rmt_status_type dp_sts;

   assign element_count_in = csr_wr_en ? csr_wr_data : element_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= rmt_pkg::ELEMENT_COUNT_RST;
      end else begin
         element_count_ff <= element_count_in;
      end
   end

   // sequencer
   rmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (ctrl_cmd)
   );

   // node memory, walk registers and output register
   rmt_datapath #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .element_count (element_count_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .cmd           (ctrl_cmd),
      .sts           (dp_sts)
   );

   // a result is loaded only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.resp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending result");

   // a taken result with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !ctrl_cmd.resp_load) |=> !rsp_tvalid)
      else $error("result repeated after transfer");

   // an accepted update never raises a result
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == rmt_pkg::CMD_UPDATE) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("update produced a result");

endmodule

/* tb/sv/range_max_checker.sv */
// ----------------------------------------------------------------------------
// range_max_checker
// watches the request, result and element count ports of the range maximum
// tree, keeps its own tree of maxima and compares every result transfer
// ----------------------------------------------------------------------------
module range_max_checker #(
   parameter int unsigned LEAF_COUNT = rmt_pkg::LEAF_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rmt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [rmt_pkg::POS_W-1:0]        csr_wr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_results
);

   typedef struct packed {
      logic [rmt_pkg::DATA_W-1:0] maximum;
      logic                       error;
   } range_result_type;

   logic signed [rmt_pkg::DATA_W-1:0] node_max [1:2*LEAF_COUNT-1];
   logic [rmt_pkg::POS_W-1:0]         elem_count;
   range_result_type                  expected_maxima [$];
   int unsigned                       errors;

   function automatic logic signed [rmt_pkg::DATA_W-1:0] larger(
      input logic signed [rmt_pkg::DATA_W-1:0] a,
      input logic signed [rmt_pkg::DATA_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // leaf write, then refresh every parent on the way to the root
   function automatic void store_value(input logic [rmt_pkg::POS_W-1:0] pos,
                                       input logic [rmt_pkg::DATA_W-1:0] val);
      int unsigned idx;
      if (pos == 0 || pos > elem_count || pos > LEAF_COUNT)
         return;
      idx = LEAF_COUNT + pos - 1;
      node_max[idx] = val;
      while (idx > 1) begin
         idx = idx >> 1;
         node_max[idx] = larger(node_max[2*idx], node_max[2*idx+1]);
      end
   endfunction

   // bottom-up walk over the half-open node range [lo, hi)
   function automatic range_result_type query_range(input logic [rmt_pkg::POS_W-1:0] lb,
                                                    input logic [rmt_pkg::POS_W-1:0] rb);
      range_result_type                  res;
      int unsigned                       lo;
      int unsigned                       hi;
      logic                              have;
      logic signed [rmt_pkg::DATA_W-1:0] best;
      res.maximum = '0;
      res.error = 1'b0;
      if (lb == 0 || lb > rb || rb > elem_count || rb > LEAF_COUNT) begin
         res.error = 1'b1;
         return res;
      end
      lo = LEAF_COUNT + lb - 1;
      hi = LEAF_COUNT + rb;
      have = 1'b0;
      best = '0;
      while (lo < hi) begin
         if (lo[0]) begin
            best = have ? larger(best, node_max[lo]) : node_max[lo];
            have = 1'b1;
            lo++;
         end
         if (hi[0]) begin
            hi--;
            best = have ? larger(best, node_max[hi]) : node_max[hi];
            have = 1'b1;
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      res.maximum = best;
      return res;
   endfunction

   always @(posedge clock) begin
      range_result_type want;
      if (reset) begin
         for (int i = 1; i < 2*LEAF_COUNT; i++)
            node_max[i] = '0;
         elem_count = rmt_pkg::ELEMENT_COUNT_RST;
         expected_maxima.delete();
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_maxima.size() == 0) begin
               errors++;
               $display("%0t unexpected result: expected none, got max %0d err %0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = expected_maxima.pop_front();
               if (rsp_tdata !== want.maximum) begin
                  errors++;
                  $display("%0t range_maximum mismatch: expected %0d, got %0d",
                           $time, $signed(want.maximum), $signed(rsp_tdata));
               end
               if (rsp_tuser !== want.error) begin
                  errors++;
                  $display("%0t range_error mismatch: expected %0b, got %0b",
                           $time, want.error, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == rmt_pkg::CMD_UPDATE)
               store_value(req_tdata[rmt_pkg::POS_LSB +: rmt_pkg::POS_W],
                           req_tdata[rmt_pkg::VAL_LSB +: rmt_pkg::DATA_W]);
            else
               expected_maxima.push_back(
                  query_range(req_tdata[rmt_pkg::LB_LSB +: rmt_pkg::POS_W],
                              req_tdata[rmt_pkg::RB_LSB +: rmt_pkg::POS_W]));
         end
         if (csr_wr_en)
            elem_count = csr_wr_data;
      end
      mismatch_count <= errors;
      pending_results <= expected_maxima.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the range maximum point update tree: directed
// corner items, then random updates and queries over several element counts
// and idle patterns, with results checked by range_max_checker
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned LEAF_COUNT = rmt_pkg::LEAF_COUNT_DEF;
   // cycles with no transfer before giving up; covers the clearing pass
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   // long enough for a trailing update or query to finish, with a comfortable margin
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned RANDOM_PER_PHASE = 185;
   localparam int unsigned NUM_PHASES = 9;
   // element count per phase; phase 0 runs on the reset value
   localparam logic [rmt_pkg::POS_W-1:0] PHASE_COUNTS [0:NUM_PHASES-1] = '{
      11'd1024, 11'd16, 11'd1, 11'd0, 11'd2047, 11'd7, 11'd100, 11'd1024, 11'd37
   };

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rmt_pkg::REQ_TDATA_W-1:0]  req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [rmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_wr_en;
   logic [rmt_pkg::POS_W-1:0]        csr_wr_data;

   int unsigned                      mismatches;
   int unsigned                      pending;
   int unsigned                      tx_idle_pct;
   int unsigned                      rx_idle_pct;
   logic [rmt_pkg::POS_W-1:0]        active_count;

   range_max_point_update_tree_top #(.LEAF_COUNT(LEAF_COUNT)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   range_max_checker #(.LEAF_COUNT(LEAF_COUNT)) u_range_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatches),
      .pending_results (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: drops tready at random at the current idle rate
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
   end

   // watchdog: any stretch of quiet cycles this long means a hang
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // fields packed lowest first, top padding bits left at zero
   function automatic logic [rmt_pkg::REQ_TDATA_W-1:0] pack_request(
      input logic [rmt_pkg::POS_W-1:0]  pos,
      input logic [rmt_pkg::DATA_W-1:0] val,
      input logic [rmt_pkg::POS_W-1:0]  lb,
      input logic [rmt_pkg::POS_W-1:0]  rb);
      logic [rmt_pkg::REQ_TDATA_W-1:0] d;
      d = '0;
      d[rmt_pkg::POS_LSB +: rmt_pkg::POS_W] = pos;
      d[rmt_pkg::VAL_LSB +: rmt_pkg::DATA_W] = val;
      d[rmt_pkg::LB_LSB +: rmt_pkg::POS_W] = lb;
      d[rmt_pkg::RB_LSB +: rmt_pkg::POS_W] = rb;
      return d;
   endfunction

   // values biased toward the extremes and the deep negative range
   function automatic logic [rmt_pkg::DATA_W-1:0] rand_value();
      case ($urandom_range(7, 0))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(100, 0) - 32'd50;
         3: return 32'hC000_0000 - $urandom_range(1 << 20, 1);
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   // mostly positions in use, sometimes anything the field allows
   function automatic int unsigned pick_position(input int unsigned lim);
      if (lim != 0 && $urandom_range(99, 0) < 88)
         return $urandom_range(lim, 1);
      return $urandom_range(2047, 0);
   endfunction

   // one request transfer; sender idles before it at the current rate and
   // puts junk on the bus while tvalid is low
   task automatic send_item(input logic cmd, input logic [rmt_pkg::REQ_TDATA_W-1:0] data);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= rmt_pkg::REQ_TDATA_W'({$urandom, $urandom, $urandom});
         req_tuser <= 1'($urandom_range(1, 0));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // unused fields get random bits, the block must ignore them
   task automatic send_update(input logic [rmt_pkg::POS_W-1:0] pos,
                              input logic [rmt_pkg::DATA_W-1:0] val);
      send_item(rmt_pkg::CMD_UPDATE,
                pack_request(pos, val, rmt_pkg::POS_W'($urandom),
                             rmt_pkg::POS_W'($urandom)));
   endtask

   task automatic send_query(input logic [rmt_pkg::POS_W-1:0] lb,
                             input logic [rmt_pkg::POS_W-1:0] rb);
      send_item(rmt_pkg::CMD_QUERY,
                pack_request(rmt_pkg::POS_W'($urandom), $urandom, lb, rb));
   endtask

   // hold off until every result is in, then let a trailing update finish
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_element_count(input logic [rmt_pkg::POS_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_count = value;
   endtask

   task automatic run_random_phase(input int unsigned num_items);
      int unsigned lim;
      int unsigned lb;
      int unsigned rb;
      int unsigned span;
      lim = (active_count > LEAF_COUNT) ? LEAF_COUNT : active_count;
      // small arrays get loaded in full first so queries see real data
      if (lim != 0 && lim <= 128)
         for (int unsigned p = 1; p <= lim; p++)
            send_update(rmt_pkg::POS_W'(p), rand_value());
      repeat (num_items) begin
         if ($urandom_range(99, 0) < 45) begin
            send_update(rmt_pkg::POS_W'(pick_position(lim)), rand_value());
         end else begin
            if (lim != 0 && $urandom_range(99, 0) < 85) begin
               lb = $urandom_range(lim, 1);
               if ($urandom_range(1, 0)) begin
                  // narrow window, catches single-node and sibling paths
                  span = (lim - lb > 8) ? 8 : lim - lb;
                  rb = lb + $urandom_range(span, 0);
               end else begin
                  rb = $urandom_range(lim, lb);
               end
            end else begin
               // noise: reversed, zero or out-of-count bounds mostly
               lb = $urandom_range(2047, 0);
               rb = $urandom_range(2047, 0);
            end
            send_query(rmt_pkg::POS_W'(lb), rmt_pkg::POS_W'(rb));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= rmt_pkg::CMD_UPDATE;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      tx_idle_pct = 16;
      rx_idle_pct = 71;
      active_count = rmt_pkg::ELEMENT_COUNT_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corners on the reset element count; the first transfer
      // waits out the clearing pass
      send_query(11'd1, 11'd1024);              // empty tree gives zero
      send_update(11'd1, 32'h7FFF_FFFF);        // largest value at first leaf
      send_update(11'd1024, 32'h8000_0000);     // smallest value at last leaf
      send_update(11'd0, 32'd5);                // position zero, ignored
      send_update(11'd1025, 32'd99);            // past the leaf count, ignored
      send_update(11'd2047, 32'd77);            // all ones position, ignored
      send_query(11'd1, 11'd1024);
      send_query(11'd1024, 11'd1024);
      send_query(11'd1, 11'd1);
      send_update(11'd2, 32'hBFFF_FFFB);        // below -(1<<30)
      send_update(11'd3, 32'h8000_0001);
      send_query(11'd2, 11'd3);                 // all-negative range
      send_query(11'd3, 11'd3);
      send_query(11'd0, 11'd5);                 // zero left bound
      send_query(11'd6, 11'd5);                 // reversed bounds
      send_query(11'd1, 11'd1025);              // right bound past count
      send_query(11'd2047, 11'd2047);
      send_query(11'd0, 11'd0);
      send_update(11'd513, 32'h5555_5555);
      send_query(11'd512, 11'd513);             // crosses the root split
      send_update(11'd1, 32'hAAAA_AAAA);        // overwrite drops the max
      send_query(11'd1, 11'd2);
      send_query(11'd1, 11'd1024);

      for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
         // idle pattern: sender light / receiver heavy, then swapped, then none
         if (ph < 3) begin
            tx_idle_pct = 16;
            rx_idle_pct = 71;
         end else if (ph < 6) begin
            tx_idle_pct = 71;
            rx_idle_pct = 16;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // register writes only with the block drained
         if (ph != 0) begin
            wait_block_idle();
            write_element_count(PHASE_COUNTS[ph]);
         end
         run_random_phase(RANDOM_PER_PHASE);
      end

      wait_block_idle();
      if (mismatches == 0 && pending == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
